// ===== src/mrpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpe_pkg: shared types and constants of the motor RLS parameter estimator
// Holds the operand type, the unit request and response structs, the shift
// selections of the multiplier and the configuration register indexes.
// ----------------------------------------------------------------------------
package mrpe_pkg;

    // Defaults of the value format.
    localparam int VALUE_WIDTH_DEF   = 48;
    localparam int FRACTION_BITS_DEF = 24;

    // Operand bus of the shared units: wide enough for any value and any gain.
    localparam int OPND_W = 64;
    typedef logic signed [OPND_W-1:0] t_opnd;

    // Right shift applied by the multiplier after the full product.
    typedef logic [1:0] t_shift;
    localparam t_shift SH_NONE = 2'd0;
    localparam t_shift SH_FRAC = 2'd1;
    localparam t_shift SH_GAIN = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST  = 3'd5;

    // Register reset values.
    localparam logic [14:0] RST_BANDWIDTH = 15'd128;
    localparam logic [31:0] RST_CUR_GAIN  = 32'd2690239;
    localparam logic [31:0] RST_VOLT_GAIN = 32'd1816207;
    localparam logic [31:0] RST_SPD_GAIN  = 32'd449767923;
    localparam logic [22:0] RST_INIT_COV  = 23'd1000000;
    localparam logic [23:0] RST_INIT_EST  = 24'd167772;

    // Request to the multiplier.
    typedef struct packed {
        logic   start;
        t_shift kind;
        t_opnd  a;
        t_opnd  b;
    } t_mul_req;

    // Request to the divider: reciprocal of den, or num / den toward zero.
    typedef struct packed {
        logic  start;
        logic  recip;
        t_opnd num;
        t_opnd den;
    } t_div_req;

    // Response of either unit, valid for one cycle with done.
    typedef struct packed {
        logic  done;
        logic  sat;
        t_opnd result;
    } t_unit_rsp;

endpackage

// ===== src/mrpe_in_if.sv =====
// ----------------------------------------------------------------------------
// mrpe_in_if: sample request channel
// Carries one set of raw current, voltage and speed samples.
// ----------------------------------------------------------------------------
interface mrpe_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] current_sample;
    logic signed [15:0] voltage_sample;
    logic signed [15:0] speed_sample;

    modport source (output valid, output current_sample, output voltage_sample,
                    output speed_sample, input ready);
    modport sink   (input valid, input current_sample, input voltage_sample,
                    input speed_sample, output ready);
endinterface

// ===== src/mrpe_out_if.sv =====
// ----------------------------------------------------------------------------
// mrpe_out_if: estimate request channel
// Carries both parameter estimates, the filtered current and the overflow flag.
// ----------------------------------------------------------------------------
interface mrpe_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] resistance_estimate;
    logic signed [47:0] emf_constant_estimate;
    logic signed [15:0] filtered_current;
    logic               overflow_flag;

    modport source (output valid, output resistance_estimate,
                    output emf_constant_estimate, output filtered_current,
                    output overflow_flag, input ready);
    modport sink   (input valid, input resistance_estimate,
                    input emf_constant_estimate, input filtered_current,
                    input overflow_flag, output ready);
endinterface

// ===== src/mrpe_mul.sv =====
// ----------------------------------------------------------------------------
// mrpe_mul: shared saturating fixed-point multiplier
// Multiplies operand magnitudes with four 32x32 partial products, shifts the
// full product right, truncating toward zero, and saturates to the value range.
// ----------------------------------------------------------------------------
module mrpe_mul #(
    parameter int VALUE_WIDTH   = mrpe_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = mrpe_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrpe_pkg::t_mul_req  i_req,
    output mrpe_pkg::t_unit_rsp o_rsp
);
    import mrpe_pkg::*;

    localparam logic [63:0]  VMAX64  = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam logic [127:0] VMAX128 = 128'(VMAX64);
    localparam logic [6:0]   AMT_FRAC = 7'(FRACTION_BITS);
    localparam logic [6:0]   AMT_GAIN = 7'(32 - FRACTION_BITS);
    localparam logic [2:0]   PH_LAST  = 3'd6;

    logic         r_busy;
    logic [2:0]   r_ph;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    t_shift       r_kind;
    logic [63:0]  r_pp;
    logic [1:0]   r_pos;
    logic [127:0] r_acc;
    logic [127:0] r_sh;
    logic         r_done;
    logic         r_sat;
    t_opnd        r_res;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [6:0]   amt;
    logic         n_sat;
    t_opnd        n_res;

    // Partial product operands follow the phase bits.
    assign a_half = r_ph[0] ? r_ma[63:32] : r_ma[31:0];
    assign b_half = r_ph[1] ? r_mb[63:32] : r_mb[31:0];

    // Final shift amount.
    always_comb begin
        unique case (r_kind)
            SH_FRAC: amt = AMT_FRAC;
            SH_GAIN: amt = AMT_GAIN;
            default: amt = 7'd0;
        endcase
    end

    // Saturation of the shifted magnitude with the product sign.
    always_comb begin
        n_sat = 1'b0;
        if (r_neg) begin
            if (r_sh > VMAX128 + 128'd1) begin
                n_sat = 1'b1;
                n_res = -t_opnd'(VMAX64) - t_opnd'(1);
            end else begin
                n_res = -t_opnd'(r_sh[63:0]);
            end
        end else begin
            if (r_sh > VMAX128) begin
                n_sat = 1'b1;
                n_res = t_opnd'(VMAX64);
            end else begin
                n_res = t_opnd'(r_sh[63:0]);
            end
        end
    end

    // Control: phase counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_ph   <= 3'd0;
                end
            end else if (r_ph == PH_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_ph <= r_ph + 3'd1;
            end
        end
    end

    // Datapath: partial products, accumulation, shift and saturation.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_ma   <= i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
            r_mb   <= i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
            r_neg  <= i_req.a[63] ^ i_req.b[63];
            r_kind <= i_req.kind;
            r_acc  <= '0;
        end
        if (r_busy && r_ph <= 3'd3) begin
            r_pp  <= {32'd0, a_half} * {32'd0, b_half};
            r_pos <= 2'({1'b0, r_ph[0]} + {1'b0, r_ph[1]});
        end
        if (r_busy && r_ph >= 3'd1 && r_ph <= 3'd4) begin
            r_acc <= r_acc + ({64'd0, r_pp} << {r_pos, 5'd0});
        end
        if (r_busy && r_ph == 3'd5) begin
            r_sh <= r_acc >> amt;
        end
        if (r_busy && r_ph == PH_LAST) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.sat    = r_sat;
    assign o_rsp.result = r_res;

endmodule

// ===== src/mrpe_div.sv =====
// ----------------------------------------------------------------------------
// mrpe_div: shared restoring divider
// One quotient bit per cycle. Gives either the saturated reciprocal
// 2^(2*FRACTION_BITS) / den or the 16-bit quotient num / den toward zero.
// ----------------------------------------------------------------------------
module mrpe_div #(
    parameter int VALUE_WIDTH   = mrpe_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = mrpe_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrpe_pkg::t_div_req  i_req,
    output mrpe_pkg::t_unit_rsp o_rsp
);
    import mrpe_pkg::*;

    localparam int          DN     = 2 * FRACTION_BITS + 1;
    localparam int          CW     = $clog2(DN + 1);
    localparam logic [63:0] VMAX64 = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DN-1:0] r_num;
    logic [DN-1:0] r_q;
    logic [63:0]   r_rem;
    logic [63:0]   r_dv;
    logic          r_neg;
    logic          r_rcp;
    logic          r_done;
    logic          r_sat;
    t_opnd         r_res;

    logic [64:0]   rem_sh;
    logic          fits;
    logic [15:0]   q16;
    logic [15:0]   v16;

    // One restoring step.
    assign rem_sh = {r_rem, r_num[DN-1]};
    assign fits   = rem_sh >= {1'b0, r_dv};

    assign q16 = r_q[15:0];
    assign v16 = r_neg ? -q16 : q16;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(DN);
                end
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end else begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            if (i_req.recip) begin
                r_num <= DN'(1) << (2 * FRACTION_BITS);
            end else begin
                r_num <= DN'(i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num));
            end
            r_dv  <= 64'(i_req.den);
            r_neg <= ~i_req.recip & i_req.num[63];
            r_rcp <= i_req.recip;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_num <= r_num << 1;
            r_rem <= fits ? 64'(rem_sh - {1'b0, r_dv}) : rem_sh[63:0];
            r_q   <= {r_q[DN-2:0], fits};
        end else if (r_busy) begin
            r_sat <= 1'b0;
            if (r_rcp) begin
                if (66'(r_q) > 66'(VMAX64)) begin
                    r_res <= t_opnd'(VMAX64);
                    r_sat <= 1'b1;
                end else begin
                    r_res <= t_opnd'(r_q);
                end
            end else begin
                r_res <= t_opnd'(signed'(v16));
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.sat    = r_sat;
    assign o_rsp.result = r_res;

endmodule

// ===== src/motor_rls_param_estimator.sv =====
// ----------------------------------------------------------------------------
// motor_rls_param_estimator: two-parameter RLS estimator of R and Ke
// Low-pass filters current and voltage, scales them and the speed, and runs
// one recursive least-squares update per sample under a microcoded sequencer
// that shares one multiplier, one divider and one saturating adder.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  i_in      in         valid / ready      current, voltage, speed samples
//  o_out     out        valid / ready      R and Ke estimates, filter, flag
//  i_cfg_*   in         write enable only  six configuration registers
//
// A sample runs 29 multiplies in the shared multiplier, three divisions in
// the shared divider, 19 adds, subtracts and the branch, and steps to accept,
// finish and hand off the result. A non-positive denominator skips the update
// and ends the sample early.
// Reset is synchronous and active low; it loads the register reset values,
// clears the filters and loads covariance and estimates. i_in.ready is high
// only between samples; a finished result waits in the output register, and
// the next sample is accepted meanwhile but holds at its end while it waits.
// ----------------------------------------------------------------------------
module motor_rls_param_estimator #(
    parameter int VALUE_WIDTH   = mrpe_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = mrpe_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mrpe_in_if.sink                           i_in,
    mrpe_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [mrpe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mrpe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mrpe_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam int F = FRACTION_BITS;

    localparam logic [63:0]        VMAX64  = (64'd1 << (W - 1)) - 64'd1;
    localparam logic signed [64:0] VMAX65  = signed'({1'b0, VMAX64});
    localparam logic signed [64:0] VMIN65  = -VMAX65 - 65'sd1;
    localparam logic               ONE_SAT = (F >= W - 1);
    localparam logic [63:0]        ONE64   = ONE_SAT ? VMAX64 : (64'd1 << F);
    localparam int                 EST_L   = (F >= 24) ? F - 24 : 0;
    localparam int                 EST_R   = (F >= 24) ? 0 : 24 - F;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Micro-operations.
    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_RCP = 3'd4;
    localparam logic [2:0] OP_BR  = 3'd5;
    localparam logic [2:0] OP_FIN = 3'd6;

    // Operand and destination slots.
    localparam logic [4:0] SL_P0   = 5'd0;
    localparam logic [4:0] SL_P1   = 5'd1;
    localparam logic [4:0] SL_P2   = 5'd2;
    localparam logic [4:0] SL_P3   = 5'd3;
    localparam logic [4:0] SL_E0   = 5'd4;
    localparam logic [4:0] SL_E1   = 5'd5;
    localparam logic [4:0] SL_PH0  = 5'd6;
    localparam logic [4:0] SL_PH1  = 5'd7;
    localparam logic [4:0] SL_YV   = 5'd8;
    localparam logic [4:0] SL_G0   = 5'd9;
    localparam logic [4:0] SL_G1   = 5'd10;
    localparam logic [4:0] SL_H0   = 5'd11;
    localparam logic [4:0] SL_H1   = 5'd12;
    localparam logic [4:0] SL_AV   = 5'd13;
    localparam logic [4:0] SL_BV   = 5'd14;
    localparam logic [4:0] SL_T0   = 5'd15;
    localparam logic [4:0] SL_T1   = 5'd16;
    localparam logic [4:0] SL_CA   = 5'd17;
    localparam logic [4:0] SL_VA   = 5'd18;
    localparam logic [4:0] SL_ONE  = 5'd19;
    localparam logic [4:0] SL_XI   = 5'd20;
    localparam logic [4:0] SL_XV   = 5'd21;
    localparam logic [4:0] SL_SP   = 5'd22;
    localparam logic [4:0] SL_CG   = 5'd23;
    localparam logic [4:0] SL_VG   = 5'd24;
    localparam logic [4:0] SL_SG   = 5'd25;
    localparam logic [4:0] SL_BWM1 = 5'd26;
    localparam logic [4:0] SL_BWE  = 5'd27;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] dst;
        logic [4:0] sa;
        logic [4:0] sb;
        t_shift     sh;
    } t_uop;

    // Microprogram of one sample: filters, scaling, gain, update.
    function automatic t_uop ucode(input logic [5:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = '{OP_MUL, SL_T0,  SL_CA,  SL_BWM1, SH_NONE};
            6'd1:  u = '{OP_ADD, SL_T0,  SL_T0,  SL_XI,   SH_NONE};
            6'd2:  u = '{OP_DIV, SL_CA,  SL_T0,  SL_BWE,  SH_NONE};
            6'd3:  u = '{OP_MUL, SL_T0,  SL_VA,  SL_BWM1, SH_NONE};
            6'd4:  u = '{OP_ADD, SL_T0,  SL_T0,  SL_XV,   SH_NONE};
            6'd5:  u = '{OP_DIV, SL_VA,  SL_T0,  SL_BWE,  SH_NONE};
            6'd6:  u = '{OP_MUL, SL_PH0, SL_CA,  SL_CG,   SH_GAIN};
            6'd7:  u = '{OP_MUL, SL_PH1, SL_SP,  SL_SG,   SH_GAIN};
            6'd8:  u = '{OP_MUL, SL_YV,  SL_VA,  SL_VG,   SH_GAIN};
            6'd9:  u = '{OP_MUL, SL_T0,  SL_P0,  SL_PH0,  SH_FRAC};
            6'd10: u = '{OP_MUL, SL_T1,  SL_P1,  SL_PH1,  SH_FRAC};
            6'd11: u = '{OP_ADD, SL_G0,  SL_T0,  SL_T1,   SH_NONE};
            6'd12: u = '{OP_MUL, SL_T0,  SL_P2,  SL_PH0,  SH_FRAC};
            6'd13: u = '{OP_MUL, SL_T1,  SL_P3,  SL_PH1,  SH_FRAC};
            6'd14: u = '{OP_ADD, SL_G1,  SL_T0,  SL_T1,   SH_NONE};
            6'd15: u = '{OP_MUL, SL_T0,  SL_PH0, SL_P0,   SH_FRAC};
            6'd16: u = '{OP_MUL, SL_T1,  SL_PH1, SL_P2,   SH_FRAC};
            6'd17: u = '{OP_ADD, SL_H0,  SL_T0,  SL_T1,   SH_NONE};
            6'd18: u = '{OP_MUL, SL_T0,  SL_PH0, SL_P1,   SH_FRAC};
            6'd19: u = '{OP_MUL, SL_T1,  SL_PH1, SL_P3,   SH_FRAC};
            6'd20: u = '{OP_ADD, SL_H1,  SL_T0,  SL_T1,   SH_NONE};
            6'd21: u = '{OP_MUL, SL_T0,  SL_H0,  SL_PH0,  SH_FRAC};
            6'd22: u = '{OP_MUL, SL_T1,  SL_H1,  SL_PH1,  SH_FRAC};
            6'd23: u = '{OP_ADD, SL_AV,  SL_T0,  SL_T1,   SH_NONE};
            6'd24: u = '{OP_ADD, SL_AV,  SL_ONE, SL_AV,   SH_NONE};
            6'd25: u = '{OP_BR,  SL_AV,  SL_AV,  SL_AV,   SH_NONE};
            6'd26: u = '{OP_RCP, SL_BV,  SL_AV,  SL_AV,   SH_NONE};
            6'd27: u = '{OP_MUL, SL_G0,  SL_G0,  SL_BV,   SH_FRAC};
            6'd28: u = '{OP_MUL, SL_G1,  SL_G1,  SL_BV,   SH_FRAC};
            6'd29: u = '{OP_MUL, SL_T0,  SL_G0,  SL_H0,   SH_FRAC};
            6'd30: u = '{OP_SUB, SL_P0,  SL_P0,  SL_T0,   SH_NONE};
            6'd31: u = '{OP_MUL, SL_T0,  SL_G0,  SL_H1,   SH_FRAC};
            6'd32: u = '{OP_SUB, SL_P1,  SL_P1,  SL_T0,   SH_NONE};
            6'd33: u = '{OP_MUL, SL_T0,  SL_G1,  SL_H0,   SH_FRAC};
            6'd34: u = '{OP_SUB, SL_P2,  SL_P2,  SL_T0,   SH_NONE};
            6'd35: u = '{OP_MUL, SL_T0,  SL_G1,  SL_H1,   SH_FRAC};
            6'd36: u = '{OP_SUB, SL_P3,  SL_P3,  SL_T0,   SH_NONE};
            6'd37: u = '{OP_MUL, SL_T0,  SL_P0,  SL_PH0,  SH_FRAC};
            6'd38: u = '{OP_MUL, SL_T1,  SL_P1,  SL_PH1,  SH_FRAC};
            6'd39: u = '{OP_ADD, SL_H0,  SL_T0,  SL_T1,   SH_NONE};
            6'd40: u = '{OP_MUL, SL_T0,  SL_P2,  SL_PH0,  SH_FRAC};
            6'd41: u = '{OP_MUL, SL_T1,  SL_P3,  SL_PH1,  SH_FRAC};
            6'd42: u = '{OP_ADD, SL_H1,  SL_T0,  SL_T1,   SH_NONE};
            6'd43: u = '{OP_MUL, SL_T0,  SL_PH0, SL_E0,   SH_FRAC};
            6'd44: u = '{OP_MUL, SL_T1,  SL_PH1, SL_E1,   SH_FRAC};
            6'd45: u = '{OP_ADD, SL_AV,  SL_T0,  SL_T1,   SH_NONE};
            6'd46: u = '{OP_SUB, SL_BV,  SL_YV,  SL_AV,   SH_NONE};
            6'd47: u = '{OP_MUL, SL_T0,  SL_H0,  SL_BV,   SH_FRAC};
            6'd48: u = '{OP_ADD, SL_E0,  SL_E0,  SL_T0,   SH_NONE};
            6'd49: u = '{OP_MUL, SL_T0,  SL_H1,  SL_BV,   SH_FRAC};
            6'd50: u = '{OP_ADD, SL_E1,  SL_E1,  SL_T0,   SH_NONE};
            default: u = '{OP_FIN, SL_T0, SL_T0, SL_T0,   SH_NONE};
        endcase
        return u;
    endfunction

    // Covariance diagonal from the integer register, saturated.
    function automatic logic signed [W-1:0] load_cov(input logic [22:0] c);
        logic [95:0] m;
        m = 96'(c) << F;
        if (m > 96'(VMAX64)) begin
            return W'(VMAX64);
        end
        return W'(m);
    endfunction

    // Estimate from the Q24 register, rescaled toward zero and saturated.
    function automatic logic signed [W-1:0] load_est(input logic [23:0] v);
        logic [23:0] a;
        logic [95:0] m;
        a = v[23] ? -v : v;
        m = (96'(a) << EST_L) >> EST_R;
        if (v[23]) begin
            if (m > 96'(VMAX64) + 96'd1) begin
                return W'(~VMAX64);
            end
            return W'(-m);
        end
        if (m > 96'(VMAX64)) begin
            return W'(VMAX64);
        end
        return W'(m);
    endfunction

    // Configuration registers.
    logic [14:0]          r_bw;
    logic [31:0]          r_cg;
    logic [31:0]          r_vg;
    logic [31:0]          r_sg;

    // Estimator state.
    logic signed [W-1:0]  r_p0, r_p1, r_p2, r_p3;
    logic signed [W-1:0]  r_e0, r_e1;
    logic signed [15:0]   r_ca, r_va;

    // Working values.
    logic signed [W-1:0]  r_ph0, r_ph1, r_yv, r_g0, r_g1, r_h0, r_h1;
    logic signed [W-1:0]  r_av, r_bv, r_t0, r_t1;
    logic signed [15:0]   r_xi, r_xv, r_sp;

    // Sequencer and output register.
    logic [1:0]           r_state;
    logic [5:0]           r_pc;
    logic                 r_sat;
    logic                 r_out_valid;
    logic [47:0]          r_out_r;
    logic [47:0]          r_out_k;
    logic [15:0]          r_out_fc;
    logic                 r_out_ov;

    t_uop                 uop;
    t_opnd                opa, opb;
    t_mul_req             mul_req;
    t_div_req             div_req;
    t_unit_rsp            mul_rsp, div_rsp;
    logic [14:0]          bw_eff;
    logic [14:0]          bw_m1;
    logic signed [64:0]   sum;
    logic                 wr_en;
    t_opnd                wr_val;
    logic                 wr_sat;
    logic                 accept;
    logic                 br_fail;

    function automatic t_opnd rd(input logic [4:0] sel);
        t_opnd v;
        unique case (sel)
            SL_P0:   v = t_opnd'(r_p0);
            SL_P1:   v = t_opnd'(r_p1);
            SL_P2:   v = t_opnd'(r_p2);
            SL_P3:   v = t_opnd'(r_p3);
            SL_E0:   v = t_opnd'(r_e0);
            SL_E1:   v = t_opnd'(r_e1);
            SL_PH0:  v = t_opnd'(r_ph0);
            SL_PH1:  v = t_opnd'(r_ph1);
            SL_YV:   v = t_opnd'(r_yv);
            SL_G0:   v = t_opnd'(r_g0);
            SL_G1:   v = t_opnd'(r_g1);
            SL_H0:   v = t_opnd'(r_h0);
            SL_H1:   v = t_opnd'(r_h1);
            SL_AV:   v = t_opnd'(r_av);
            SL_BV:   v = t_opnd'(r_bv);
            SL_T0:   v = t_opnd'(r_t0);
            SL_T1:   v = t_opnd'(r_t1);
            SL_CA:   v = t_opnd'(r_ca);
            SL_VA:   v = t_opnd'(r_va);
            SL_ONE:  v = signed'(ONE64);
            SL_XI:   v = t_opnd'(r_xi);
            SL_XV:   v = t_opnd'(r_xv);
            SL_SP:   v = t_opnd'(r_sp);
            SL_CG:   v = signed'(64'(r_cg));
            SL_VG:   v = signed'(64'(r_vg));
            SL_SG:   v = signed'(64'(r_sg));
            SL_BWM1: v = signed'(64'(bw_m1));
            SL_BWE:  v = signed'(64'(bw_eff));
            default: v = '0;
        endcase
        return v;
    endfunction

    // A zero bandwidth acts as one.
    assign bw_eff = (r_bw == '0) ? 15'd1 : r_bw;
    assign bw_m1  = (r_bw == '0) ? 15'd0 : r_bw - 15'd1;

    // Decode and operand fetch.
    assign uop    = ucode(r_pc);
    always_comb begin
        opa = rd(uop.sa);
        opb = rd(uop.sb);
    end
    assign accept = i_in.valid && i_in.ready;
    assign br_fail = r_av[W-1] || (r_av == '0);

    // Requests to the shared units.
    assign mul_req.start = (r_state == ST_RUN) && (uop.op == OP_MUL);
    assign mul_req.kind  = uop.sh;
    assign mul_req.a     = opa;
    assign mul_req.b     = opb;
    assign div_req.start = (r_state == ST_RUN) && ((uop.op == OP_DIV) || (uop.op == OP_RCP));
    assign div_req.recip = (uop.op == OP_RCP);
    assign div_req.num   = opa;
    assign div_req.den   = opb;

    mrpe_mul #(.VALUE_WIDTH(W), .FRACTION_BITS(F)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    mrpe_div #(.VALUE_WIDTH(W), .FRACTION_BITS(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Saturating adder and the slot write port.
    always_comb begin
        if (uop.op == OP_SUB) begin
            sum = 65'(opa) - 65'(opb);
        end else begin
            sum = 65'(opa) + 65'(opb);
        end
        wr_en  = 1'b0;
        wr_sat = 1'b0;
        wr_val = t_opnd'(sum);
        if (r_state == ST_RUN && (uop.op == OP_ADD || uop.op == OP_SUB)) begin
            wr_en = 1'b1;
            if (sum > VMAX65) begin
                wr_val = t_opnd'(VMAX65);
                wr_sat = 1'b1;
            end else if (sum < VMIN65) begin
                wr_val = t_opnd'(VMIN65);
                wr_sat = 1'b1;
            end
            if (uop.sa == SL_ONE && ONE_SAT) begin
                wr_sat = 1'b1;
            end
        end else if (r_state == ST_WAIT && mul_rsp.done) begin
            wr_en  = 1'b1;
            wr_val = mul_rsp.result;
            wr_sat = mul_rsp.sat;
        end else if (r_state == ST_WAIT && div_rsp.done) begin
            wr_en  = 1'b1;
            wr_val = div_rsp.result;
            wr_sat = div_rsp.sat;
        end
    end

    // Sequencer, configuration, estimator state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_bw        <= RST_BANDWIDTH;
            r_cg        <= RST_CUR_GAIN;
            r_vg        <= RST_VOLT_GAIN;
            r_sg        <= RST_SPD_GAIN;
            r_p0        <= load_cov(RST_INIT_COV);
            r_p1        <= '0;
            r_p2        <= '0;
            r_p3        <= load_cov(RST_INIT_COV);
            r_e0        <= load_est(RST_INIT_EST);
            r_e1        <= load_est(RST_INIT_EST);
            r_ca        <= '0;
            r_va        <= '0;
        end else begin
            // A finished sample refills the output register itself.
            if (o_out.valid && o_out.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes must arrive only while idle; the block itself does not check this.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BANDWIDTH: r_bw <= i_cfg_data[14:0];
                    CFG_CUR_GAIN:  r_cg <= i_cfg_data;
                    CFG_VOLT_GAIN: r_vg <= i_cfg_data;
                    CFG_SPD_GAIN:  r_sg <= i_cfg_data;
                    CFG_INIT_COV: begin
                        r_p0 <= load_cov(i_cfg_data[22:0]);
                        r_p1 <= '0;
                        r_p2 <= '0;
                        r_p3 <= load_cov(i_cfg_data[22:0]);
                    end
                    CFG_INIT_EST: begin
                        r_e0 <= load_est(i_cfg_data[23:0]);
                        r_e1 <= load_est(i_cfg_data[23:0]);
                    end
                    default: ;
                endcase
            end

            // State slots written by the microprogram.
            if (wr_en) begin
                r_sat <= r_sat | wr_sat;
                unique case (uop.dst)
                    SL_P0:   r_p0 <= wr_val[W-1:0];
                    SL_P1:   r_p1 <= wr_val[W-1:0];
                    SL_P2:   r_p2 <= wr_val[W-1:0];
                    SL_P3:   r_p3 <= wr_val[W-1:0];
                    SL_E0:   r_e0 <= wr_val[W-1:0];
                    SL_E1:   r_e1 <= wr_val[W-1:0];
                    SL_CA:   r_ca <= wr_val[15:0];
                    SL_VA:   r_va <= wr_val[15:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_RUN;
                        r_pc    <= '0;
                        r_sat   <= 1'b0;
                    end
                end
                ST_RUN: begin
                    unique case (uop.op)
                        OP_MUL, OP_DIV, OP_RCP: r_state <= ST_WAIT;
                        OP_ADD, OP_SUB:         r_pc <= r_pc + 6'd1;
                        OP_BR: begin
                            // A non-positive denominator holds covariance and estimates.
                            if (br_fail) begin
                                r_sat   <= 1'b1;
                                r_state <= ST_DONE;
                            end else begin
                                r_pc <= r_pc + 6'd1;
                            end
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_WAIT: begin
                    if (mul_rsp.done || div_rsp.done) begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= ST_RUN;
                    end
                end
                default: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Payload registers: samples, working values and the result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xi <= i_in.current_sample;
            r_xv <= i_in.voltage_sample;
            r_sp <= i_in.speed_sample;
        end
        if (wr_en) begin
            unique case (uop.dst)
                SL_PH0:  r_ph0 <= wr_val[W-1:0];
                SL_PH1:  r_ph1 <= wr_val[W-1:0];
                SL_YV:   r_yv  <= wr_val[W-1:0];
                SL_G0:   r_g0  <= wr_val[W-1:0];
                SL_G1:   r_g1  <= wr_val[W-1:0];
                SL_H0:   r_h0  <= wr_val[W-1:0];
                SL_H1:   r_h1  <= wr_val[W-1:0];
                SL_AV:   r_av  <= wr_val[W-1:0];
                SL_BV:   r_bv  <= wr_val[W-1:0];
                SL_T0:   r_t0  <= wr_val[W-1:0];
                SL_T1:   r_t1  <= wr_val[W-1:0];
                default: ;
            endcase
        end
        if (r_state == ST_DONE && (!r_out_valid || o_out.ready)) begin
            r_out_r  <= 48'(t_opnd'(r_e0));
            r_out_k  <= 48'(t_opnd'(r_e1));
            r_out_fc <= r_ca;
            r_out_ov <= r_sat;
        end
    end

    assign i_in.ready                  = (r_state == ST_IDLE);
    assign o_out.valid                 = r_out_valid;
    assign o_out.resistance_estimate   = r_out_r;
    assign o_out.emf_constant_estimate = r_out_k;
    assign o_out.filtered_current      = r_out_fc;
    assign o_out.overflow_flag         = r_out_ov;

    // The shared units answer only while the sequencer waits for them.
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> r_state == ST_WAIT)
        else $error("multiplier answered outside the wait state");

    // Only one shared unit is active at a time.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_rsp.done && div_rsp.done))
        else $error("both units answered in the same cycle");

    // An accepted sample starts the microprogram from its first step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RUN && r_pc == '0))
        else $error("sample did not start the microprogram");

    // A finished sample holds while the previous result is still pending.
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_out.ready) |=> r_state == ST_DONE)
        else $error("finished sample overwrote a pending result");

endmodule
